// File: src/ddc_pkg.sv
// Shared constants, codes and state type for the dual deque operation checker.
package ddc_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FUNC_W    = 4;
  localparam int unsigned STS_W     = 2;

  localparam logic [FUNC_W-1:0] FN_CLEAR  = 4'd0;
  localparam logic [FUNC_W-1:0] FN_LOAD   = 4'd1;
  localparam logic [FUNC_W-1:0] FN_SA     = 4'd2;
  localparam logic [FUNC_W-1:0] FN_SB     = 4'd3;
  localparam logic [FUNC_W-1:0] FN_SS     = 4'd4;
  localparam logic [FUNC_W-1:0] FN_PA     = 4'd5;
  localparam logic [FUNC_W-1:0] FN_PB     = 4'd6;
  localparam logic [FUNC_W-1:0] FN_RA     = 4'd7;
  localparam logic [FUNC_W-1:0] FN_RB     = 4'd8;
  localparam logic [FUNC_W-1:0] FN_RR     = 4'd9;
  localparam logic [FUNC_W-1:0] FN_RRA    = 4'd10;
  localparam logic [FUNC_W-1:0] FN_RRB    = 4'd11;
  localparam logic [FUNC_W-1:0] FN_RRR    = 4'd12;
  localparam logic [FUNC_W-1:0] FN_FINISH = 4'd13;

  localparam logic [STS_W-1:0] STS_ACC = 2'd0;
  localparam logic [STS_W-1:0] STS_ERR = 2'd1;
  localparam logic [STS_W-1:0] STS_OK  = 2'd2;
  localparam logic [STS_W-1:0] STS_KO  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIMPLE,
    ST_RD0,
    ST_RD1,
    ST_WR0,
    ST_WR1,
    ST_FIN
  } seq_state_e;

endpackage

// File: src/ddc_ram.sv
// Simple dual-port stack store with one write port and one registered read port.
module ddc_ram #(
  parameter int unsigned DEPTH = ddc_pkg::DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  logic [ddc_pkg::DATA_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [ddc_pkg::DATA_W-1:0] rdata_o
);

  logic [ddc_pkg::DATA_W-1:0] mem [DEPTH];
  logic [ddc_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/ddc_seq.sv
// Sequencer, ring pointers for both stacks, and the order compare over stack A.
module ddc_seq #(
  parameter int unsigned DEPTH = ddc_pkg::DEPTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [ddc_pkg::FUNC_W-1:0]             func_i,
  input  logic signed [ddc_pkg::DATA_W-1:0]      value_i,
  output logic                                   busy_o,
  output logic                                   done_o,
  output logic [ddc_pkg::STS_W-1:0]              status_o,
  output logic [$clog2(DEPTH+1)-1:0]             a_count_o,
  output logic [$clog2(DEPTH+1)-1:0]             b_count_o,
  output logic [1:0]                             mem_we_o,
  output logic [1:0][$clog2(DEPTH)-1:0]          mem_waddr_o,
  output logic [1:0][ddc_pkg::DATA_W-1:0]        mem_wdata_o,
  output logic [1:0]                             mem_re_o,
  output logic [1:0][$clog2(DEPTH)-1:0]          mem_raddr_o,
  input  logic [1:0][ddc_pkg::DATA_W-1:0]        mem_rdata_i
);

  import ddc_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW:0]   DEP_W  = (CW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEP_C  = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW + 1)'(base) + (CW + 1)'(off);
    if (sum >= DEP_W) begin
      sum = sum - DEP_W;
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] base);
    return (base == LAST_A) ? '0 : base + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] base);
    return (base == '0) ? LAST_A : base - AW'(1);
  endfunction

  seq_state_e state_q, state_d;

  logic [FUNC_W-1:0]        func_q;
  logic signed [DATA_W-1:0] value_q;
  logic [1:0][AW-1:0]       top_q;
  logic [1:0][CW-1:0]       fill_q;
  logic                     halted_q;
  logic                     done_q;
  logic [STS_W-1:0]         status_q;
  logic [1:0][DATA_W-1:0]   tmp_q;
  logic [AW-1:0]            ptr_q;
  logic [CW-1:0]            issued_q;
  logic                     rv_q;
  logic                     have_prev_q;
  logic                     ko_q;
  logic signed [DATA_W-1:0] prev_q;

  logic [1:0]          swp, rot, rrt, pin, pout, full;
  logic [1:0][AW-1:0]  a_p1, a_end, a_last, a_dec, a_inc;
  logic                fin_re, fin_end, cmp_gt;

  always_comb begin
    full[0] = (fill_q[0] == DEP_C);
    full[1] = (fill_q[1] == DEP_C);
    swp[0]  = (func_q == FN_SA || func_q == FN_SS) && (fill_q[0] > CW'(1));
    swp[1]  = (func_q == FN_SB || func_q == FN_SS) && (fill_q[1] > CW'(1));
    rot[0]  = (func_q == FN_RA || func_q == FN_RR) && (fill_q[0] != '0);
    rot[1]  = (func_q == FN_RB || func_q == FN_RR) && (fill_q[1] != '0);
    rrt[0]  = (func_q == FN_RRA || func_q == FN_RRR) && (fill_q[0] != '0);
    rrt[1]  = (func_q == FN_RRB || func_q == FN_RRR) && (fill_q[1] != '0);
    pin[0]  = (func_q == FN_PA) && (fill_q[1] != '0) && !full[0];
    pin[1]  = (func_q == FN_PB) && (fill_q[0] != '0) && !full[1];
    pout[0] = pin[1];
    pout[1] = pin[0];
    for (int s = 0; s < 2; s++) begin
      a_p1[s]   = ring_add(top_q[s], CW'(1));
      a_end[s]  = ring_add(top_q[s], fill_q[s]);
      a_last[s] = ring_add(top_q[s], fill_q[s] - CW'(1));
      a_dec[s]  = ring_dec(top_q[s]);
      a_inc[s]  = ring_inc(top_q[s]);
    end
  end

  assign fin_re  = (state_q == ST_FIN) && (issued_q != fill_q[0]);
  assign fin_end = (issued_q == fill_q[0]) && !rv_q;
  assign cmp_gt  = prev_q > $signed(mem_rdata_i[0]);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (!halted_q && func_i == FN_FINISH) begin
            state_d = ST_FIN;
          end else if (!halted_q && func_i >= FN_SA && func_i <= FN_RRR) begin
            state_d = ST_RD0;
          end else begin
            state_d = ST_SIMPLE;
          end
        end
      end
      ST_SIMPLE: state_d = ST_IDLE;
      ST_RD0:    state_d = ST_RD1;
      ST_RD1:    state_d = ST_WR0;
      ST_WR0:    state_d = ST_WR1;
      ST_WR1:    state_d = ST_IDLE;
      ST_FIN: begin
        if (fin_end) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we_o    = '0;
    mem_waddr_o = top_q;
    mem_wdata_o = tmp_q;
    mem_re_o    = '0;
    mem_raddr_o = top_q;
    case (state_q)
      ST_SIMPLE: begin
        mem_we_o[0]    = (func_q == FN_LOAD) && !halted_q && !full[0];
        mem_waddr_o[0] = a_end[0];
        mem_wdata_o[0] = value_q;
      end
      ST_RD0: begin
        for (int s = 0; s < 2; s++) begin
          mem_re_o[s]    = swp[s] | rot[s] | rrt[s] | pout[s];
          mem_raddr_o[s] = rrt[s] ? a_last[s] : top_q[s];
        end
      end
      ST_RD1: begin
        mem_re_o    = swp;
        mem_raddr_o = a_p1;
      end
      ST_WR0: begin
        mem_we_o    = swp;
        mem_wdata_o = mem_rdata_i;
      end
      ST_WR1: begin
        for (int s = 0; s < 2; s++) begin
          mem_we_o[s]    = swp[s] | rot[s] | rrt[s] | pin[s];
          mem_waddr_o[s] = swp[s] ? a_p1[s] : (rot[s] ? a_end[s] : a_dec[s]);
          mem_wdata_o[s] = pin[s] ? tmp_q[1-s] : tmp_q[s];
        end
      end
      ST_FIN: begin
        mem_re_o[0]    = fin_re;
        mem_raddr_o[0] = ptr_q;
      end
      default: begin
        mem_we_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      top_q       <= '0;
      fill_q      <= '0;
      halted_q    <= 1'b0;
      done_q      <= 1'b0;
      status_q    <= STS_ACC;
      ptr_q       <= '0;
      issued_q    <= '0;
      rv_q        <= 1'b0;
      have_prev_q <= 1'b0;
      ko_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            ptr_q       <= top_q[0];
            issued_q    <= '0;
            rv_q        <= 1'b0;
            have_prev_q <= 1'b0;
            ko_q        <= 1'b0;
          end
        end
        ST_SIMPLE: begin
          done_q <= 1'b1;
          if (func_q == FN_CLEAR) begin
            top_q    <= '0;
            fill_q   <= '0;
            halted_q <= 1'b0;
            status_q <= STS_ACC;
          end else if (halted_q) begin
            status_q <= STS_ERR;
          end else if (func_q == FN_LOAD && !full[0]) begin
            fill_q[0] <= fill_q[0] + CW'(1);
            status_q  <= STS_ACC;
          end else begin
            halted_q <= 1'b1;
            status_q <= STS_ERR;
          end
        end
        ST_WR1: begin
          done_q   <= 1'b1;
          status_q <= STS_ACC;
          for (int s = 0; s < 2; s++) begin
            if (rot[s] | pout[s]) begin
              top_q[s] <= a_inc[s];
            end else if (rrt[s] | pin[s]) begin
              top_q[s] <= a_dec[s];
            end
            if (pout[s]) begin
              fill_q[s] <= fill_q[s] - CW'(1);
            end else if (pin[s]) begin
              fill_q[s] <= fill_q[s] + CW'(1);
            end
          end
        end
        ST_FIN: begin
          if (fin_re) begin
            ptr_q    <= ring_inc(ptr_q);
            issued_q <= issued_q + CW'(1);
          end
          rv_q <= fin_re;
          if (rv_q) begin
            have_prev_q <= 1'b1;
            if (have_prev_q && cmp_gt) begin
              ko_q <= 1'b1;
            end
          end
          if (fin_end) begin
            done_q   <= 1'b1;
            status_q <= (ko_q || fill_q[1] != '0) ? STS_KO : STS_OK;
          end
        end
        default: begin
          done_q <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      func_q  <= func_i;
      value_q <= value_i;
    end
    if (state_q == ST_RD1) begin
      tmp_q <= mem_rdata_i;
    end
    if (state_q == ST_FIN && rv_q) begin
      prev_q <= $signed(mem_rdata_i[0]);
    end
  end

  assign busy_o    = (state_q != ST_IDLE);
  assign done_o    = done_q;
  assign status_o  = status_q;
  assign a_count_o = fill_q[0];
  assign b_count_o = fill_q[1];

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == ST_IDLE) && ($past(state_q) != ST_IDLE))
    else $error("result strobe outside the end of an item");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted request did not start work");

  a_fill_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(fill_q) |-> ($past(state_q) == ST_SIMPLE) || ($past(state_q) == ST_WR1))
    else $error("stack count changed outside an update step");

  a_halt_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(halted_q) |-> ($past(state_q) == ST_SIMPLE) && ($past(func_q) != FN_CLEAR))
    else $error("halt raised by an unexpected request");

endmodule

// File: src/dual_deque_op_checker.sv
// Top level of the dual deque operation checker: sequencer and two stack stores.
//
//  channel   direction  handshake                  payload
//  request   in         start_i, busy_o            func_i, value_i
//  result    out        done_o (one-cycle strobe)  status_o, a_count_o, b_count_o
//
//  Clear, load, invalid and halted requests pass through the simple step; swap, push and rotate take
//  four access steps on the single write and registered read port of each store.
//  Finish runs the order compare, which walks A one element a cycle.
//  busy_o is low in the cycle the result strobe shows, so a new request may enter then.
//  Reset clears pointers, counts and halt; store contents stay undefined until written.
//  The receiver cannot stall: each result is valid for its single strobe cycle only.
module dual_deque_op_checker #(
  parameter int unsigned DEPTH = ddc_pkg::DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [ddc_pkg::FUNC_W-1:0]        func_i,
  input  logic signed [ddc_pkg::DATA_W-1:0] value_i,
  output logic                              done_o,
  output logic [ddc_pkg::STS_W-1:0]         status_o,
  output logic [$clog2(DEPTH+1)-1:0]        a_count_o,
  output logic [$clog2(DEPTH+1)-1:0]        b_count_o
);

  import ddc_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic [1:0]             mem_we;
  logic [1:0][AW-1:0]     mem_waddr;
  logic [1:0][DATA_W-1:0] mem_wdata;
  logic [1:0]             mem_re;
  logic [1:0][AW-1:0]     mem_raddr;
  logic [1:0][DATA_W-1:0] mem_rdata;

  ddc_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .func_i      (func_i),
    .value_i     (value_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .status_o    (status_o),
    .a_count_o   (a_count_o),
    .b_count_o   (b_count_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  ddc_ram #(
    .DEPTH (DEPTH)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (mem_we[0]),
    .waddr_i (mem_waddr[0]),
    .wdata_i (mem_wdata[0]),
    .re_i    (mem_re[0]),
    .raddr_i (mem_raddr[0]),
    .rdata_o (mem_rdata[0])
  );

  ddc_ram #(
    .DEPTH (DEPTH)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (mem_we[1]),
    .waddr_i (mem_waddr[1]),
    .wdata_i (mem_wdata[1]),
    .re_i    (mem_re[1]),
    .raddr_i (mem_raddr[1]),
    .rdata_o (mem_rdata[1])
  );

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the dual deque operation checker: driven requests, predicted results.
module testbench;
  import ddc_pkg::*;

  localparam int unsigned STACK_DEPTH   = DEPTH_DEF;
  localparam int unsigned CNT_W         = $clog2(STACK_DEPTH + 1);
  localparam int unsigned N_REQUESTS    = 1300;
  localparam int unsigned CALM_TAIL     = 150;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned PRINT_CAP     = 100;
  localparam int          ST_A          = 0;
  localparam int          ST_B          = 1;

  localparam logic [FUNC_W-1:0] FN_BAD_LO = 4'd14;
  localparam logic [FUNC_W-1:0] FN_BAD_HI = 4'd15;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] value;
    bit                hold;
  } request_t;

  typedef struct {
    logic [STS_W-1:0] status;
    logic [CNT_W-1:0] a_count;
    logic [CNT_W-1:0] b_count;
  } outcome_t;

  logic                     clk_i   = 1'b0;
  logic                     rst_ni  = 1'b0;
  logic                     start_i = 1'b0;
  logic [FUNC_W-1:0]        func_i  = FN_CLEAR;
  logic signed [DATA_W-1:0] value_i = '0;
  logic                     busy_o;
  logic                     done_o;
  logic [STS_W-1:0]         status_o;
  logic [CNT_W-1:0]         a_count_o;
  logic [CNT_W-1:0]         b_count_o;

  request_t request_q [$];
  outcome_t outcome_q [$];

  logic [DATA_W-1:0] deq_mem  [2][STACK_DEPTH];
  int unsigned       deq_head [2];
  int unsigned       deq_len  [2];
  bit                halted;

  bit          taken         = 1'b0;
  int unsigned gap_left      = 0;
  int unsigned stall_cnt     = 0;
  int unsigned mismatch_cnt  = 0;
  int unsigned requests_sent = 0;
  int unsigned results_seen  = 0;
  int unsigned n_ok          = 0;
  int unsigned n_ko          = 0;
  int unsigned n_err         = 0;
  int unsigned peak_a        = 0;

  dual_deque_op_checker #(
    .DEPTH(STACK_DEPTH)
  ) u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .func_i   (func_i),
    .value_i  (value_i),
    .done_o   (done_o),
    .status_o (status_o),
    .a_count_o(a_count_o),
    .b_count_o(b_count_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic int unsigned slot(int s, int unsigned i);
    return (deq_head[s] + i) % STACK_DEPTH;
  endfunction

  task automatic swap_pair(int s);
    logic [DATA_W-1:0] t;
    if (deq_len[s] > 1) begin
      t = deq_mem[s][slot(s, 0)];
      deq_mem[s][slot(s, 0)] = deq_mem[s][slot(s, 1)];
      deq_mem[s][slot(s, 1)] = t;
    end
  endtask

  task automatic move_top(int dst, int src);
    if (deq_len[src] != 0 && deq_len[dst] < STACK_DEPTH) begin
      deq_head[dst] = (deq_head[dst] + STACK_DEPTH - 1) % STACK_DEPTH;
      deq_mem[dst][deq_head[dst]] = deq_mem[src][deq_head[src]];
      deq_head[src] = (deq_head[src] + 1) % STACK_DEPTH;
      deq_len[src]--;
      deq_len[dst]++;
    end
  endtask

  task automatic rotate_up(int s);
    logic [DATA_W-1:0] v;
    if (deq_len[s] != 0) begin
      v = deq_mem[s][slot(s, 0)];
      deq_head[s] = (deq_head[s] + 1) % STACK_DEPTH;
      deq_mem[s][slot(s, deq_len[s] - 1)] = v;
    end
  endtask

  task automatic rotate_down(int s);
    logic [DATA_W-1:0] v;
    if (deq_len[s] != 0) begin
      v = deq_mem[s][slot(s, deq_len[s] - 1)];
      deq_head[s] = (deq_head[s] + STACK_DEPTH - 1) % STACK_DEPTH;
      deq_mem[s][deq_head[s]] = v;
    end
  endtask

  function automatic bit a_in_order();
    for (int unsigned i = 0; i + 1 < deq_len[ST_A]; i++) begin
      if ($signed(deq_mem[ST_A][slot(ST_A, i)]) > $signed(deq_mem[ST_A][slot(ST_A, i + 1)])) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic execute_request(input logic [FUNC_W-1:0] func, input logic [DATA_W-1:0] value,
                                 output outcome_t res);
    res.status = STS_ACC;
    if (func == FN_CLEAR) begin
      deq_head[ST_A] = 0;
      deq_len[ST_A]  = 0;
      deq_head[ST_B] = 0;
      deq_len[ST_B]  = 0;
      halted         = 1'b0;
    end else if (halted) begin
      res.status = STS_ERR;
    end else begin
      case (func)
        FN_LOAD: begin
          if (deq_len[ST_A] >= STACK_DEPTH) begin
            res.status = STS_ERR;
            halted     = 1'b1;
          end else begin
            deq_mem[ST_A][slot(ST_A, deq_len[ST_A])] = value;
            deq_len[ST_A]++;
          end
        end
        FN_SA:  swap_pair(ST_A);
        FN_SB:  swap_pair(ST_B);
        FN_SS: begin
          swap_pair(ST_A);
          swap_pair(ST_B);
        end
        FN_PA:  move_top(ST_A, ST_B);
        FN_PB:  move_top(ST_B, ST_A);
        FN_RA:  rotate_up(ST_A);
        FN_RB:  rotate_up(ST_B);
        FN_RR: begin
          rotate_up(ST_A);
          rotate_up(ST_B);
        end
        FN_RRA: rotate_down(ST_A);
        FN_RRB: rotate_down(ST_B);
        FN_RRR: begin
          rotate_down(ST_A);
          rotate_down(ST_B);
        end
        FN_FINISH: begin
          res.status = (a_in_order() && deq_len[ST_B] == 0) ? STS_OK : STS_KO;
        end
        default: begin
          res.status = STS_ERR;
          halted     = 1'b1;
        end
      endcase
    end
    res.a_count = CNT_W'(deq_len[ST_A]);
    res.b_count = CNT_W'(deq_len[ST_B]);
  endtask

  task automatic note_mismatch(input string msg);
    if (mismatch_cnt < PRINT_CAP) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    mismatch_cnt++;
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return DATA_W'(int'($urandom_range(0, 15)) - 8);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [FUNC_W-1:0] pick_op();
    return FUNC_W'($urandom_range(FN_SA, FN_RRR));
  endfunction

  task automatic queue_request(input logic [FUNC_W-1:0] f, input logic [DATA_W-1:0] v,
                               input bit hold = 1'b0);
    request_t r;
    r.func  = f;
    r.value = v;
    r.hold  = hold;
    request_q.push_back(r);
  endtask

  task automatic queue_ordered_load(input int unsigned n);
    longint lvl;
    longint ceiling;
    ceiling = 64'sd2147483647 - 4 * longint'(n);
    lvl     = longint'($signed(pick_value()));
    if (lvl > ceiling) begin
      lvl = ceiling;
    end
    repeat (n) begin
      queue_request(FN_LOAD, lvl[DATA_W-1:0]);
      lvl += $urandom_range(0, 3);
    end
  endtask

  task automatic queue_full_load();
    repeat (STACK_DEPTH) queue_request(FN_LOAD, pick_value());
  endtask

  task automatic build_directed();
    queue_request(FN_CLEAR, '0);
    queue_request(FN_RA, '0);
    queue_request(FN_PA, '0);
    queue_request(FN_SB, '0);
    queue_request(FN_LOAD, 32'h8000_0000);
    queue_request(FN_LOAD, 32'h7fff_ffff);
    queue_request(FN_LOAD, 32'h0000_0000);
    queue_request(FN_LOAD, 32'hffff_ffff);
    queue_request(FN_FINISH, '0);
    queue_request(FN_SA, '0);
    queue_request(FN_PB, '0);
    queue_request(FN_PB, '0);
    queue_request(FN_SS, '0);
    queue_request(FN_RR, '0);
    queue_request(FN_RRR, '0);
    queue_request(FN_RB, '0);
    queue_request(FN_RRA, '0);
    queue_request(FN_RRB, '0);
    queue_request(FN_PA, '0, 1'b1);
    queue_request(FN_FINISH, '0);
    queue_request(FN_BAD_LO, '0);
    queue_request(FN_LOAD, 32'h1234_5678);
    queue_request(FN_CLEAR, '0);
    queue_request(FN_LOAD, 32'd5);
    queue_request(FN_FINISH, '0);
    queue_request(FN_BAD_HI, 32'hffff_ffff);
  endtask

  task automatic build_random();
    int unsigned kind;
    int unsigned n;
    int unsigned k;
    while (request_q.size() < N_REQUESTS) begin
      kind = $urandom_range(0, 19);
      queue_request(FN_CLEAR, pick_value(), $urandom_range(0, 9) == 0);
      if (kind < 11) begin
        n = ($urandom_range(0, 7) == 0) ? STACK_DEPTH : $urandom_range(0, 12);
        repeat (n) queue_request(FN_LOAD, pick_value());
        repeat ($urandom_range(1, 16)) begin
          if ($urandom_range(0, 9) == 0) begin
            queue_request(FN_LOAD, pick_value());
          end else begin
            queue_request(pick_op(), pick_value());
          end
        end
        queue_request(FN_FINISH, pick_value());
      end else if (kind < 15) begin
        n = ($urandom_range(0, 5) == 0) ? STACK_DEPTH : $urandom_range(0, 16);
        queue_ordered_load(n);
        k = $urandom_range(0, n);
        repeat (k) queue_request(FN_PB, pick_value());
        if ($urandom_range(0, 1) == 0) begin
          queue_request(FN_FINISH, pick_value());
        end
        repeat (k) queue_request(FN_PA, pick_value());
        if ($urandom_range(0, 1) == 0) begin
          repeat (n) queue_request(FN_RA, pick_value());
        end else begin
          queue_request(FN_SA, pick_value());
          queue_request(FN_SA, pick_value());
        end
        queue_request(FN_FINISH, pick_value());
      end else if (kind == 15) begin
        queue_full_load();
        queue_request(FN_LOAD, pick_value());
        repeat ($urandom_range(1, 4)) queue_request(FUNC_W'($urandom_range(1, 15)), pick_value());
      end else if (kind == 16) begin
        queue_full_load();
        repeat (STACK_DEPTH) queue_request(FN_PB, pick_value());
        queue_request(FN_LOAD, pick_value());
        queue_request(FN_PB, pick_value());
        queue_request(FN_PA, pick_value());
        queue_request(FN_RRB, pick_value());
        queue_request(FN_FINISH, pick_value());
      end else if (kind == 17) begin
        queue_full_load();
        queue_request(FN_PB, pick_value());
        queue_request(FN_LOAD, pick_value());
        queue_request(FN_PA, pick_value());
        queue_request(FN_RRA, pick_value());
        queue_request(FN_SS, pick_value());
        queue_request(FN_FINISH, pick_value());
      end else begin
        repeat ($urandom_range(1, 8)) queue_request(FUNC_W'($urandom_range(0, 15)), $urandom);
      end
    end
  endtask

  // drive requests; hold each one until accepted
  always @(negedge clk_i) begin
    request_t r;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!(start_i && !taken)) begin
      if (gap_left != 0) begin
        start_i  <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (request_q.size() == 0 || (request_q[0].hold && outcome_q.size() != 0)) begin
        start_i <= 1'b0;
      end else begin
        r = request_q.pop_front();
        start_i <= 1'b1;
        func_i  <= r.func;
        value_i <= r.value;
        if (request_q.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
          gap_left <= $urandom_range(1, 10);
        end
      end
    end
  end

  // check results, then predict the request taken at this edge
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        results_seen++;
        if (outcome_q.size() == 0) begin
          note_mismatch($sformatf("result with nothing pending, status %0d", status_o));
        end else begin
          want = outcome_q.pop_front();
          if (status_o !== want.status) begin
            note_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
          end
          if (a_count_o !== want.a_count) begin
            note_mismatch($sformatf("a_count %0d, expected %0d", a_count_o, want.a_count));
          end
          if (b_count_o !== want.b_count) begin
            note_mismatch($sformatf("b_count %0d, expected %0d", b_count_o, want.b_count));
          end
        end
      end
      if (start_i && busy_o === 1'b0) begin
        execute_request(func_i, value_i, want);
        outcome_q.push_back(want);
        requests_sent++;
        if (want.status == STS_OK) n_ok++;
        if (want.status == STS_KO) n_ko++;
        if (want.status == STS_ERR) n_err++;
        if (want.a_count > peak_a) peak_a = want.a_count;
      end
    end
    taken <= rst_ni && start_i && busy_o === 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || done_o === 1'b1 || (start_i && busy_o === 1'b0)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("timeout: no request or result for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    deq_head[ST_A] = 0;
    deq_len[ST_A]  = 0;
    deq_head[ST_B] = 0;
    deq_len[ST_B]  = 0;
    halted         = 1'b0;
    build_directed();
    build_random();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    while (request_q.size() != 0 || start_i || outcome_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    $display("covered %0d requests and %0d results: %0d OK and %0d KO verdicts, %0d errors",
             requests_sent, results_seen, n_ok, n_ko, n_err);
    $display("stack A peaked at %0d of %0d elements, %0d mismatches",
             peak_a, STACK_DEPTH, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: dual_deque_op_checker.f
src/ddc_pkg.sv
src/ddc_ram.sv
src/ddc_seq.sv
src/dual_deque_op_checker.sv
sim/testbench.sv
